/* rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types, codes and constants of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned BITCNT_W   = 4;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0]   ACK_TIMEOUT_RESET = 8'd50;
  localparam logic [BYTE_W-1:0]   MSB_MASK          = 8'h80;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE     = 4'd8;

  // command codes on the input port
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_ACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_NACK = 3'd5;

  // register indexes
  localparam logic [0:0] REG_ACK_TIMEOUT = 1'b0;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE    = 2'd0,
    ERR_BUSY    = 2'd1,
    ERR_TIMEOUT = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    IC_TICK,
    IC_START,
    IC_STOP,
    IC_WRITE,
    IC_READ_ACK,
    IC_READ_NACK
  } item_cls_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST1   = 4'd1,
    PH_ST2   = 4'd2,
    PH_ST3   = 4'd3,
    PH_SP1   = 4'd4,
    PH_SP2   = 4'd5,
    PH_WR    = 4'd6,
    PH_WREL  = 4'd7,
    PH_WSCL  = 4'd8,
    PH_WPOLL = 4'd9,
    PH_RD    = 4'd10,
    PH_RACK  = 4'd11
  } phase_t;

  typedef struct packed {
    item_cls_t         cls;
    logic [BYTE_W-1:0] tx_byte;
    logic              sda_line;
  } item_t;

  typedef struct packed {
    logic  push;
    logic  full;
  } q_ctrl_t;

endpackage

/* rtl/i2cm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// accepts input items and classifies the command code for the back end
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_sda_line,
  input  logic              q_full,
  output q_ctrl_t           q_ctrl,
  output item_t             q_item
);

  item_cls_t cls;
  logic      seen_r;
  logic      seen_nxt;

  always_comb begin
    unique case (in_cmd)
      CMD_START:     cls = IC_START;
      CMD_STOP:      cls = IC_STOP;
      CMD_WRITE:     cls = IC_WRITE;
      CMD_READ_ACK:  cls = IC_READ_ACK;
      CMD_READ_NACK: cls = IC_READ_NACK;
      default:       cls = IC_TICK;
    endcase
  end

  assign in_ready        = !q_full;
  assign q_ctrl.push     = in_valid && in_ready;
  assign q_ctrl.full     = q_full;
  assign q_item.cls      = cls;
  assign q_item.tx_byte  = in_tx_byte;
  assign q_item.sda_line = in_sda_line;

  // sticky flag: at least one item taken since reset
  assign seen_nxt = seen_r || q_ctrl.push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctrl.push |-> !q_full) else $error("push into full queue");

  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |=> seen_r) else $error("seen flag dropped");

  a_seen_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctrl.push |=> seen_r) else $error("seen flag not set");

endmodule

/* rtl/i2cm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_queue
// short item queue between the front and the back end
// ----------------------------------------------------------------------------
module i2cm_queue import i2cm_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_ctrl_t q_ctrl,
  input  item_t   wr_item,
  output logic    full,
  output logic    rd_valid,
  input  logic    pop,
  output item_t   rd_item
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;
  logic            do_pop;

  assign full     = (count_r == FullCnt);
  assign rd_valid = (count_r != '0);
  assign do_pop   = pop && rd_valid;
  assign rd_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_ctrl.push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (q_ctrl.push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !q_ctrl.push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctrl.push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt) else $error("queue count out of range");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !q_ctrl.push) |=> (count_r == $past(count_r) - CntW'(1)))
    else $error("queue count not decremented");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctrl.push |-> !q_ctrl.full) else $error("queue overflow");

endmodule

/* rtl/i2cm_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// back end: runs the scl/sda waveform one item at a time, holds the result
// ----------------------------------------------------------------------------
module i2cm_engine import i2cm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [BYTE_W-1:0] ack_timeout_limit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_scl_level,
  output logic              out_sda_release,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [BYTE_W-1:0] out_rx_byte,
  output logic              out_acked,
  output logic [ERR_W-1:0]  out_error_code
);

  phase_t              phase_r,   phase_nxt;
  item_cls_t           active_r,  active_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0]   shift_r,   shift_nxt;
  logic [1:0]          tick_r,    tick_nxt;
  logic [BYTE_W-1:0]   poll_r,    poll_nxt;
  logic                scl_r,     scl_nxt;
  logic                sda_r,     sda_nxt;
  logic [BYTE_W-1:0]   rx_r,      rx_nxt;
  logic                acked_r,   acked_nxt;
  err_t                err_r,     err_nxt;
  logic                done_r,    done_nxt;
  logic                valid_r,   valid_nxt;
  logic [BITCNT_W-1:0] bit_inc;
  logic                fire;

  assign fire    = q_valid && (!valid_r || out_ready);
  assign q_pop   = fire;
  assign bit_inc = bit_cnt_r + BITCNT_W'(1);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (q_item.cls)
          IC_START:                  phase_nxt = PH_ST1;
          IC_STOP:                   phase_nxt = PH_SP1;
          IC_WRITE:                  phase_nxt = PH_WR;
          IC_READ_ACK, IC_READ_NACK: phase_nxt = PH_RD;
          default:                   phase_nxt = PH_IDLE;
        endcase
      end
      PH_ST1:  phase_nxt = q_item.sda_line ? PH_ST2 : PH_IDLE;
      PH_ST2:  phase_nxt = PH_ST3;
      PH_ST3:  phase_nxt = PH_IDLE;
      PH_SP1:  phase_nxt = PH_SP2;
      PH_SP2:  phase_nxt = PH_IDLE;
      PH_WR: begin
        if (tick_r == 2'd2 && bit_inc >= BITS_PER_BYTE) begin
          phase_nxt = PH_WREL;
        end
      end
      PH_WREL: phase_nxt = PH_WSCL;
      PH_WSCL: phase_nxt = PH_WPOLL;
      PH_WPOLL: begin
        priority if (!q_item.sda_line) begin
          phase_nxt = PH_IDLE;
        end else if (poll_r >= ack_timeout_limit) begin
          phase_nxt = PH_SP1;
        end else begin
          phase_nxt = PH_WPOLL;
        end
      end
      PH_RD: begin
        if (tick_r == 2'd3 && bit_inc >= BITS_PER_BYTE) begin
          phase_nxt = PH_RACK;
        end
      end
      PH_RACK: begin
        if (tick_r == 2'd2) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    active_nxt  = active_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    poll_nxt    = poll_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rx_nxt      = rx_r;
    acked_nxt   = acked_r;
    err_nxt     = err_r;
    done_nxt    = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (q_item.cls != IC_TICK) begin
          active_nxt  = q_item.cls;
          err_nxt     = ERR_NONE;
          bit_cnt_nxt = '0;
          tick_nxt    = '0;
          poll_nxt    = '0;
          unique case (q_item.cls)
            IC_START: sda_nxt = 1'b1;
            IC_STOP: begin
              scl_nxt = 1'b0;
              sda_nxt = 1'b0;
            end
            IC_WRITE: begin
              acked_nxt = 1'b0;
              shift_nxt = q_item.tx_byte;
              scl_nxt   = 1'b0;
            end
            default: begin
              shift_nxt = '0;
              sda_nxt   = 1'b1;
            end
          endcase
        end
      end
      PH_ST1: begin
        if (!q_item.sda_line) begin
          err_nxt  = ERR_BUSY;
          done_nxt = 1'b1;
        end else begin
          scl_nxt = 1'b1;
        end
      end
      PH_ST2: sda_nxt = 1'b0;
      PH_ST3: begin
        if (q_item.sda_line) begin
          err_nxt = ERR_BUSY;
        end else begin
          scl_nxt = 1'b0;
        end
        done_nxt = 1'b1;
      end
      PH_SP1: scl_nxt = 1'b1;
      PH_SP2: begin
        sda_nxt = 1'b1;
        if (active_r == IC_WRITE) begin
          err_nxt   = ERR_TIMEOUT;
          acked_nxt = 1'b0;
        end
        done_nxt = 1'b1;
      end
      PH_WR: begin
        unique case (tick_r)
          2'd0: begin
            sda_nxt   = |(shift_r & MSB_MASK);
            shift_nxt = {shift_r[BYTE_W-2:0], 1'b0};
            tick_nxt  = 2'd1;
          end
          2'd1: begin
            scl_nxt  = 1'b1;
            tick_nxt = 2'd2;
          end
          default: begin
            scl_nxt     = 1'b0;
            tick_nxt    = 2'd0;
            bit_cnt_nxt = bit_inc;
          end
        endcase
      end
      PH_WREL: sda_nxt = 1'b1;
      PH_WSCL: begin
        scl_nxt  = 1'b1;
        poll_nxt = '0;
      end
      PH_WPOLL: begin
        priority if (!q_item.sda_line) begin
          scl_nxt   = 1'b0;
          acked_nxt = 1'b1;
          done_nxt  = 1'b1;
        end else if (poll_r >= ack_timeout_limit) begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end else begin
          poll_nxt = poll_r + BYTE_W'(1);
        end
      end
      PH_RD: begin
        unique case (tick_r)
          2'd0: begin
            scl_nxt  = 1'b0;
            tick_nxt = 2'd1;
          end
          2'd1: tick_nxt = 2'd2;
          2'd2: begin
            scl_nxt  = 1'b1;
            tick_nxt = 2'd3;
          end
          default: begin
            shift_nxt   = {shift_r[BYTE_W-2:0], q_item.sda_line};
            tick_nxt    = 2'd0;
            bit_cnt_nxt = bit_inc;
          end
        endcase
      end
      PH_RACK: begin
        unique case (tick_r)
          2'd0: begin
            scl_nxt  = 1'b0;
            sda_nxt  = (active_r != IC_READ_ACK);
            tick_nxt = 2'd1;
          end
          2'd1: begin
            scl_nxt  = 1'b1;
            tick_nxt = 2'd2;
          end
          default: begin
            scl_nxt  = 1'b0;
            tick_nxt = 2'd0;
            rx_nxt   = shift_r;
            done_nxt = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      active_r  <= IC_TICK;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      tick_r    <= '0;
      poll_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      rx_r      <= '0;
      acked_r   <= 1'b0;
      err_r     <= ERR_NONE;
      done_r    <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (fire) begin
        phase_r   <= phase_nxt;
        active_r  <= active_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        tick_r    <= tick_nxt;
        poll_r    <= poll_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        rx_r      <= rx_nxt;
        acked_r   <= acked_nxt;
        err_r     <= err_nxt;
        done_r    <= done_nxt;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_scl_level   = scl_r;
  assign out_sda_release = sda_r;
  assign out_busy_res    = (phase_r != PH_IDLE);
  assign out_done_res    = done_r;
  assign out_rx_byte     = rx_r;
  assign out_acked       = acked_r;
  assign out_error_code  = err_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (phase_r == PH_IDLE)) else $error("done while busy");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= BITS_PER_BYTE) else $error("bit count overrun");

  a_timeout_not_acked: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r == ERR_TIMEOUT) |-> !acked_r) else $error("acked after timeout");

  a_tick3_read: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_r == 2'd3) |-> (phase_r == PH_RD)) else $error("tick 3 outside read");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (valid_r && $stable(phase_r) && $stable(scl_r)))
    else $error("result changed while stalled");

endmodule

/* rtl/i2c_master_bit_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// i2c master bit engine: start, stop, byte write with ack polling, byte read
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_ready | cmd, tx_byte, sda_line
//   out_    | output    | out_valid/out_ready | scl_level .. error_code
//   cfg     | apb write | psel/penable      | ack_timeout_limit at 0x0
//
// one item per cycle sustained while out_ready holds, set by the single-step engine update
// an accepted item is written into the queue, then the engine registers its result onto out_
// the queue lets the input side keep taking items while out_ stalls, until the queue is full
// rst_n synchronous: engine idle, lines released, queue empty, limit 50
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core import i2cm_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [BYTE_W-1:0]  in_tx_byte,
  input  logic               in_sda_line,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_scl_level,
  output logic               out_sda_release,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [BYTE_W-1:0]  out_rx_byte,
  output logic               out_acked,
  output logic [ERR_W-1:0]   out_error_code,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  q_ctrl_t           q_ctrl;
  item_t             push_item;
  item_t             pop_item;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [BYTE_W-1:0] limit_r, limit_nxt;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_ACK_TIMEOUT);

  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      limit_nxt = pwdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ACK_TIMEOUT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign prdata = reg_sel ? {{(PDATA_W-BYTE_W){1'b0}}, limit_r} : '0;

  i2cm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_tx_byte  (in_tx_byte),
    .in_sda_line (in_sda_line),
    .q_full      (q_full),
    .q_ctrl      (q_ctrl),
    .q_item      (push_item)
  );

  i2cm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_ctrl   (q_ctrl),
    .wr_item  (push_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_item  (pop_item)
  );

  i2cm_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .ack_timeout_limit (limit_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_level     (out_scl_level),
    .out_sda_release   (out_sda_release),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_rx_byte       (out_rx_byte),
    .out_acked         (out_acked),
    .out_error_code    (out_error_code)
  );

endmodule

/* tb/i2c_master_bit_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_checker
// watches the item and result channels and the register port of the i2c
// master bit engine, predicts the bus levels that each accepted item leads
// to and compares every result against the oldest prediction
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_checker import i2cm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [BYTE_W-1:0]  in_tx_byte,
  input  logic               in_sda_line,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_scl_level,
  input  logic               out_sda_release,
  input  logic               out_busy_res,
  input  logic               out_done_res,
  input  logic [BYTE_W-1:0]  out_rx_byte,
  input  logic               out_acked,
  input  logic [ERR_W-1:0]   out_error_code,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 mismatch_count,
  output int                 pending_levels
);

  localparam logic [PADDR_W-1:0] ACK_LIMIT_ADDR = PADDR_W'({REG_ACK_TIMEOUT, 2'b00});
  localparam int                 MAX_REPORTS    = 10;

  typedef struct packed {
    logic              scl;
    logic              sda_rel;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rx;
    logic              acked;
    logic [ERR_W-1:0]  err;
  } bus_levels_t;

  bus_levels_t expected_levels[$];
  int          result_index;

  // engine copy
  phase_t              eng_phase;
  logic [CMD_W-1:0]    eng_cmd;
  logic [BITCNT_W-1:0] eng_bits;
  logic [BYTE_W-1:0]   eng_shift;
  logic [1:0]          eng_ticks;
  logic [BYTE_W-1:0]   eng_polls;
  logic [BYTE_W-1:0]   timeout_limit;
  logic                scl_drv;
  logic                sda_drv;
  logic [BYTE_W-1:0]   rx_held;
  logic                acked_held;
  err_t                err_held;

  function automatic bus_levels_t advance_engine(input logic [CMD_W-1:0] cmd,
                                                 input logic [BYTE_W-1:0] txb,
                                                 input logic sda);
    bus_levels_t lv;
    logic        fin;
    fin = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        if (cmd >= CMD_START && cmd <= CMD_READ_NACK) begin
          eng_cmd   = cmd;
          err_held  = ERR_NONE;
          eng_bits  = '0;
          eng_ticks = '0;
          eng_polls = '0;
          case (cmd)
            CMD_START: begin
              sda_drv   = 1'b1;
              eng_phase = PH_ST1;
            end
            CMD_STOP: begin
              scl_drv   = 1'b0;
              sda_drv   = 1'b0;
              eng_phase = PH_SP1;
            end
            CMD_WRITE: begin
              acked_held = 1'b0;
              eng_shift  = txb;
              scl_drv    = 1'b0;
              eng_phase  = PH_WR;
            end
            default: begin
              eng_shift = '0;
              sda_drv   = 1'b1;
              eng_phase = PH_RD;
            end
          endcase
        end
      end
      PH_ST1: begin
        if (!sda) begin
          err_held  = ERR_BUSY;
          fin       = 1'b1;
          eng_phase = PH_IDLE;
        end else begin
          scl_drv   = 1'b1;
          eng_phase = PH_ST2;
        end
      end
      PH_ST2: begin
        sda_drv   = 1'b0;
        eng_phase = PH_ST3;
      end
      PH_ST3: begin
        if (sda) begin
          err_held = ERR_BUSY;
        end else begin
          scl_drv = 1'b0;
        end
        fin       = 1'b1;
        eng_phase = PH_IDLE;
      end
      PH_SP1: begin
        scl_drv   = 1'b1;
        eng_phase = PH_SP2;
      end
      PH_SP2: begin
        sda_drv = 1'b1;
        // a stop that ends a write can only come from an ack timeout
        if (eng_cmd == CMD_WRITE) begin
          err_held   = ERR_TIMEOUT;
          acked_held = 1'b0;
        end
        fin       = 1'b1;
        eng_phase = PH_IDLE;
      end
      PH_WR: begin
        case (eng_ticks)
          2'd0: begin
            sda_drv   = (eng_shift & MSB_MASK) != '0;
            eng_shift = eng_shift << 1;
            eng_ticks = 2'd1;
          end
          2'd1: begin
            scl_drv   = 1'b1;
            eng_ticks = 2'd2;
          end
          default: begin
            scl_drv   = 1'b0;
            eng_ticks = 2'd0;
            eng_bits  = eng_bits + 1'b1;
            if (eng_bits >= BITS_PER_BYTE) eng_phase = PH_WREL;
          end
        endcase
      end
      PH_WREL: begin
        sda_drv   = 1'b1;
        eng_phase = PH_WSCL;
      end
      PH_WSCL: begin
        scl_drv   = 1'b1;
        eng_polls = '0;
        eng_phase = PH_WPOLL;
      end
      PH_WPOLL: begin
        if (!sda) begin
          scl_drv    = 1'b0;
          acked_held = 1'b1;
          fin        = 1'b1;
          eng_phase  = PH_IDLE;
        end else if (eng_polls >= timeout_limit) begin
          scl_drv   = 1'b0;
          sda_drv   = 1'b0;
          eng_phase = PH_SP1;
        end else begin
          eng_polls = eng_polls + 1'b1;
        end
      end
      PH_RD: begin
        case (eng_ticks)
          2'd0: begin
            scl_drv   = 1'b0;
            eng_ticks = 2'd1;
          end
          2'd1: eng_ticks = 2'd2;
          2'd2: begin
            scl_drv   = 1'b1;
            eng_ticks = 2'd3;
          end
          default: begin
            eng_shift = {eng_shift[BYTE_W-2:0], sda};
            eng_ticks = 2'd0;
            eng_bits  = eng_bits + 1'b1;
            if (eng_bits >= BITS_PER_BYTE) eng_phase = PH_RACK;
          end
        endcase
      end
      PH_RACK: begin
        case (eng_ticks)
          2'd0: begin
            scl_drv   = 1'b0;
            sda_drv   = (eng_cmd != CMD_READ_ACK);
            eng_ticks = 2'd1;
          end
          2'd1: begin
            scl_drv   = 1'b1;
            eng_ticks = 2'd2;
          end
          default: begin
            scl_drv   = 1'b0;
            eng_ticks = 2'd0;
            rx_held   = eng_shift;
            fin       = 1'b1;
            eng_phase = PH_IDLE;
          end
        endcase
      end
      default: eng_phase = PH_IDLE;
    endcase
    lv.scl     = scl_drv;
    lv.sda_rel = sda_drv;
    lv.busy    = (eng_phase != PH_IDLE);
    lv.done    = fin;
    lv.rx      = rx_held;
    lv.acked   = acked_held;
    lv.err     = err_held;
    return lv;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_levels = 0;
    result_index   = 0;
  end

  always @(posedge clk) begin
    bus_levels_t got;
    bus_levels_t want;
    if (!rst_n) begin
      eng_phase     = PH_IDLE;
      eng_cmd       = '0;
      eng_bits      = '0;
      eng_shift     = '0;
      eng_ticks     = '0;
      eng_polls     = '0;
      timeout_limit = ACK_TIMEOUT_RESET;
      scl_drv       = 1'b1;
      sda_drv       = 1'b1;
      rx_held       = '0;
      acked_held    = 1'b0;
      err_held      = ERR_NONE;
      expected_levels.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ACK_LIMIT_ADDR)
        timeout_limit = pwdata[BYTE_W-1:0];

      if (out_valid && out_ready) begin
        got = '{out_scl_level, out_sda_release, out_busy_res, out_done_res,
                out_rx_byte, out_acked, out_error_code};
        if (expected_levels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d arrived with no item outstanding: scl %b sda %b busy %b",
                     result_index, got.scl, got.sda_rel, got.busy);
        end else begin
          want = expected_levels.pop_front();
          if (got.scl !== want.scl || got.sda_rel !== want.sda_rel ||
              got.busy !== want.busy || got.done !== want.done ||
              got.rx !== want.rx || got.acked !== want.acked || got.err !== want.err) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("result %0d mismatch", result_index);
              $display("  expected scl %b sda %b busy %b done %b rx %h acked %b err %0d",
                       want.scl, want.sda_rel, want.busy, want.done, want.rx,
                       want.acked, want.err);
              $display("  actual   scl %b sda %b busy %b done %b rx %h acked %b err %0d",
                       got.scl, got.sda_rel, got.busy, got.done, got.rx,
                       got.acked, got.err);
            end
          end
        end
        result_index++;
      end

      if (in_valid && in_ready)
        expected_levels.push_back(advance_engine(in_cmd, in_tx_byte, in_sda_line));
    end
    pending_levels = expected_levels.size();
  end

endmodule

/* tb/i2c_master_bit_engine_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_tb
// drives start, stop, write and read sequences with bus levels chosen to
// pass or break each step, plus idle noise, through several ack timeout
// settings and idling mixes; the checker beside the block judges results
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_tb;
  import i2cm_pkg::*;

  localparam logic [CMD_W-1:0]   CMD_UNDEF_LO   = 3'd6;
  localparam logic [CMD_W-1:0]   CMD_UNDEF_HI   = 3'd7;
  localparam logic [PADDR_W-1:0] ACK_LIMIT_ADDR = PADDR_W'({REG_ACK_TIMEOUT, 2'b00});
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 20;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   in_cmd = CMD_TICK;
  logic [BYTE_W-1:0]  in_tx_byte = '0;
  logic               in_sda_line = 1'b1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_scl_level;
  logic               out_sda_release;
  logic               out_busy_res;
  logic               out_done_res;
  logic [BYTE_W-1:0]  out_rx_byte;
  logic               out_acked;
  logic [ERR_W-1:0]   out_error_code;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic in_acc  = 1'b0;
  logic apb_acc = 1'b0;
  int   mismatch_count;
  int   pending_levels;
  int   cycle_count = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   ack_limit = int'(ACK_TIMEOUT_RESET);
  int   items_sent = 0;

  i2c_master_bit_engine_core dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cmd, .in_tx_byte, .in_sda_line,
    .out_valid, .out_ready, .out_scl_level, .out_sda_release, .out_busy_res,
    .out_done_res, .out_rx_byte, .out_acked, .out_error_code,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  i2c_master_bit_engine_checker u_bus_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_cmd, .in_tx_byte, .in_sda_line,
    .out_valid, .out_ready, .out_scl_level, .out_sda_release, .out_busy_res,
    .out_done_res, .out_rx_byte, .out_acked, .out_error_code,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count, .pending_levels
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_acc  <= in_valid && in_ready;
    apb_acc <= psel && penable && pwrite && pready;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] txb,
                       input logic sda);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_tx_byte  <= txb;
    in_sda_line <= sda;
    do @(negedge clk); while (!in_acc);
    items_sent++;
  endtask

  // a tick now and then carries a command, which a busy engine ignores
  task automatic bus_tick(input logic sda);
    logic [CMD_W-1:0] cmd;
    cmd = ($urandom_range(0, 7) == 0) ? CMD_W'($urandom_range(0, 7)) : CMD_TICK;
    offer(cmd, BYTE_W'($urandom), sda);
  endtask

  task automatic start_seq(input bit fail_early, input bit fail_late);
    offer(CMD_START, BYTE_W'($urandom), 1'($urandom));
    bus_tick(!fail_early);
    if (!fail_early) begin
      bus_tick(1'($urandom));
      bus_tick(fail_late);
    end
  endtask

  task automatic stop_seq();
    offer(CMD_STOP, BYTE_W'($urandom), 1'($urandom));
    repeat (2) bus_tick(1'($urandom));
  endtask

  // more high polls than the limit allows runs into the timeout stop
  task automatic write_seq(input logic [BYTE_W-1:0] data, input int high_polls);
    offer(CMD_WRITE, data, 1'($urandom));
    repeat (3 * int'(BITS_PER_BYTE) + 2) bus_tick(1'($urandom));
    if (high_polls > ack_limit) begin
      repeat (ack_limit + 1) bus_tick(1'b1);
      repeat (2) bus_tick(1'($urandom));
    end else begin
      repeat (high_polls) bus_tick(1'b1);
      bus_tick(1'b0);
    end
  endtask

  task automatic read_seq(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
    offer(cmd, BYTE_W'($urandom), 1'($urandom));
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      repeat (3) bus_tick(1'($urandom));
      bus_tick(data[i]);
    end
    repeat (3) bus_tick(1'($urandom));
  endtask

  task automatic idle_noise();
    int n;
    logic [CMD_W-1:0] cmd;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_TICK;
        1:       cmd = CMD_UNDEF_LO;
        default: cmd = CMD_UNDEF_HI;
      endcase
      offer(cmd, BYTE_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_levels == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_ack_limit(input int value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ACK_LIMIT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_acc);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ack_limit = value;
  endtask

  task automatic random_transaction();
    int sel;
    int polls;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      start_seq($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    end else if (sel < 35) begin
      stop_seq();
    end else if (sel < 65) begin
      if (ack_limit <= 10 && $urandom_range(0, 3) == 0) polls = ack_limit + 1;
      else polls = $urandom_range(0, (ack_limit < 5) ? ack_limit : 5);
      write_seq(BYTE_W'($urandom), polls);
    end else if (sel < 90) begin
      read_seq($urandom_range(0, 1) ? CMD_READ_ACK : CMD_READ_NACK, BYTE_W'($urandom));
    end else begin
      idle_noise();
    end
  endtask

  initial begin
    int phase_limits[4];
    int phase_gaps[4];
    int phase_stalls[4];
    int target;
    phase_limits = '{0, 255, 3, 0};
    phase_gaps   = '{0, 60, 0, 6};
    phase_stalls = '{0, 0, 60, 6};
    phase_limits[3] = $urandom_range(1, 20);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: start good and broken, stop, byte extremes, both reads, idle codes, timeout at limit 0
    start_seq(1'b0, 1'b0);
    start_seq(1'b1, 1'b0);
    start_seq(1'b0, 1'b1);
    stop_seq();
    write_seq(8'hFF, 0);
    read_seq(CMD_READ_ACK, 8'hFF);
    read_seq(CMD_READ_NACK, 8'h00);
    offer(CMD_UNDEF_LO, 8'h00, 1'b0);
    offer(CMD_UNDEF_HI, 8'hFF, 1'b1);
    offer(CMD_TICK, 8'h5A, 1'b0);
    set_ack_limit(0);
    write_seq(8'hA5, 1);

    for (int p = 0; p < 4; p++) begin
      set_ack_limit(phase_limits[p]);
      gap_pct   = phase_gaps[p];
      stall_pct = phase_stalls[p];
      if (p == 0) hold_req++;
      if (p == 1) write_seq(BYTE_W'($urandom), ack_limit + 1);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_transaction();
    end

    in_valid <= 1'b0;
    wait (pending_levels == 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
